@@ hw/rtl/ptw_pkg.sv @@
// Shared types and constants for the four-level page table walker.
// Used by every module under hw/rtl; depends on nothing.
package ptw_pkg;

    localparam int VaWidth    = 48;
    localparam int EntryWidth = 64;
    localparam int AddrWidth  = 52;
    localparam int IdxWidth   = 9;

    // tdata of the slave side: virtual_address, entry_data
    localparam int InDataWidth  = 112;
    // tdata of the master side: address, page_size, zero fill
    localparam int OutDataWidth = 56;

    localparam int PageSizeBit = 7;

    typedef enum logic
    {
        CMD_START    = 1'b0,
        CMD_RESPONSE = 1'b1
    } command_t;

    typedef enum logic [1:0]
    {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0]
    {
        SIZE_4K = 2'd0,
        SIZE_2M = 2'd1,
        SIZE_1G = 2'd2
    } page_size_t;

    // Level codes: level 4 is 3 down to level 1 is 0
    localparam logic [1:0] LVL_4 = 2'd3;
    localparam logic [1:0] LVL_3 = 2'd2;
    localparam logic [1:0] LVL_2 = 2'd1;
    localparam logic [1:0] LVL_1 = 2'd0;

    typedef struct packed
    {
        command_t              command;
        logic [VaWidth-1:0]    virtual_address;
        logic [EntryWidth-1:0] entry_data;
    } item_t;

    typedef struct packed
    {
        kind_t                result_kind;
        logic [AddrWidth-1:0] address;
        page_size_t           page_size;
    } result_t;

endpackage

@@ hw/rtl/ptw_in_stage.sv @@
// Input register of the page table walker: captures one transfer per
// cycle while empty or while held_take frees it. Depends on ptw_pkg.
module ptw_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ptw_pkg::item_t in_item,
    output logic          held_valid,
    input  logic          held_take,
    output ptw_pkg::item_t held_item
);
    import ptw_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || held_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !held_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ hw/rtl/ptw_walk_engine.sv @@
// Walk state and per-item decision logic of the page table walker.
// Depends on ptw_pkg; sits between ptw_in_stage and ptw_out_stage.
module ptw_walk_engine
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ptw_pkg::AddrWidth-1:0]   cfg_wdata,
    input  logic                            advance,
    input  ptw_pkg::item_t                  item,
    output ptw_pkg::result_t                result
);
    import ptw_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [1:0]           level_reg;
    logic [1:0]           level_next;
    logic [VaWidth-1:0]   held_reg;
    logic [VaWidth-1:0]   held_next;
    logic [AddrWidth-1:0] base_reg;
    logic [1:0]           next_level;
    logic [IdxWidth-1:0]  next_index;
    logic                 huge_bit;

    assign next_level = level_reg - 2'd1;
    assign huge_bit   = item.entry_data[PageSizeBit];

    always_comb
    begin
        case (next_level)
            LVL_4:   next_index = held_reg[47:39];
            LVL_3:   next_index = held_reg[38:30];
            LVL_2:   next_index = held_reg[29:21];
            default: next_index = held_reg[20:12];
        endcase
    end

    always_comb
    begin
        busy_next          = busy_reg;
        level_next         = level_reg;
        held_next          = held_reg;
        result.result_kind = KIND_ERROR;
        result.address     = '0;
        result.page_size   = SIZE_4K;

        if (item.command == CMD_START)
        begin
            if (!busy_reg)
            begin
                busy_next          = 1'b1;
                level_next         = LVL_4;
                held_next          = item.virtual_address;
                result.result_kind = KIND_READ;
                // wraps modulo 2^52
                result.address     = base_reg + {{(AddrWidth-IdxWidth-3){1'b0}},
                                     item.virtual_address[47:39], 3'b000};
            end
        end
        else if (busy_reg)
        begin
            if (item.entry_data == '0)
            begin
                busy_next          = 1'b0;
                result.result_kind = KIND_FAULT;
            end
            else if (level_reg == LVL_3 && huge_bit)
            begin
                busy_next          = 1'b0;
                result.result_kind = KIND_DONE;
                result.address     = {item.entry_data[51:30], held_reg[29:0]};
                result.page_size   = SIZE_1G;
            end
            else if (level_reg == LVL_2 && huge_bit)
            begin
                busy_next          = 1'b0;
                result.result_kind = KIND_DONE;
                result.address     = {item.entry_data[51:21], held_reg[20:0]};
                result.page_size   = SIZE_2M;
            end
            else if (level_reg == LVL_1)
            begin
                busy_next          = 1'b0;
                result.result_kind = KIND_DONE;
                result.address     = {item.entry_data[51:12], held_reg[11:0]};
                result.page_size   = SIZE_4K;
            end
            else
            begin
                level_next         = next_level;
                result.result_kind = KIND_READ;
                // index times 8 never carries past the 4 KB frame
                result.address     = {item.entry_data[51:12], next_index, 3'b000};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            level_reg <= LVL_1;
            held_reg  <= '0;
            base_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                held_reg  <= held_next;
            end
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    // A start taken while idle must leave the walker busy at the top level
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.command == CMD_START && !busy_reg
        |=> busy_reg && level_reg == LVL_4)
        else $error("start did not arm the walk");

    // A finished or faulted walk returns the walker to idle
    a_end_idles: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (result.result_kind == KIND_DONE || result.result_kind == KIND_FAULT)
        |=> !busy_reg)
        else $error("walker still busy after walk ended");

    // A protocol error leaves the walk state untouched
    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.result_kind == KIND_ERROR
        |=> busy_reg == $past(busy_reg) && level_reg == $past(level_reg))
        else $error("protocol error changed walk state");

    // Faults and errors carry a zero address and size
    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (result.result_kind == KIND_FAULT || result.result_kind == KIND_ERROR)
        |-> result.address == '0 && result.page_size == SIZE_4K)
        else $error("fault or error with nonzero payload");

endmodule

@@ hw/rtl/ptw_out_stage.sv @@
// Result register of the page table walker: holds one result until transfer.
// Depends on ptw_pkg.
module ptw_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    output logic             load_ready,
    input  ptw_pkg::result_t load_result,
    output logic             out_valid,
    input  logic             out_ready,
    output ptw_pkg::result_t out_result
);
    import ptw_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ hw/rtl/four_level_page_table_walker.sv @@
// Four-level page table walker: one result per start or response item.
// Items pass the input, then the result register. Throughput: one item per
// cycle with m_tready high; the input and result registers let a new
// transfer in while a result waits. Reset: walker idle, table_base 0.
// Depends on ptw_pkg, ptw_in_stage, ptw_walk_engine, ptw_out_stage.
module four_level_page_table_walker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ptw_pkg::AddrWidth-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [47:0] virtual_address, [111:48] entry_data
    input  logic [ptw_pkg::InDataWidth-1:0]     s_tdata,
    // [0] command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [51:0] address, [53:52] page_size, [55:54] zero
    output logic [ptw_pkg::OutDataWidth-1:0]    m_tdata,
    // [1:0] result_kind
    output logic [1:0]                          m_tuser
);
    import ptw_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    logic    load_ready;
    result_t step_result;
    result_t out_result;

    assign in_item.command         = command_t'(s_tuser);
    assign in_item.virtual_address = s_tdata[VaWidth-1:0];
    assign in_item.entry_data      = s_tdata[VaWidth+EntryWidth-1:VaWidth];

    // advance an item into the result register when there is room
    assign advance = held_valid && load_ready;

    ptw_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_take  (advance),
        .held_item  (held_item)
    );

    ptw_walk_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (held_item),
        .result    (step_result)
    );

    ptw_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_ready  (load_ready),
        .load_result (step_result),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tdata = {2'b00, out_result.page_size, out_result.address};
    assign m_tuser = out_result.result_kind;

endmodule
